// ===== design/text_mode_terminal_writer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Text-mode terminal writer: assertion macros
// Shorthand for the clocked checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define TMTW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tmtw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtw_pkg
// Screen geometry, character codes and types of the text-mode terminal writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtw_pkg;

	// screen geometry
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int TAB_STOP = 8;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int OUT_W  = 11;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [COL_W:0]    colx_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [OUT_W-1:0]  out_idx_t;
	typedef logic [7:0]        code_t;
	typedef logic [7:0]        attr_t;
	typedef logic [15:0]       cell_t;

	// control codes
	localparam code_t CODE_BACKSPACE = 8'd8;
	localparam code_t CODE_TAB       = 8'd9;
	localparam code_t CODE_NEWLINE   = 8'd10;
	localparam code_t CODE_RETURN    = 8'd13;
	localparam code_t CODE_SPACE     = 8'h20;

	localparam attr_t RESET_ATTR = 8'h0F;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_BLANK
	} state_t;

endpackage

`default_nettype wire

// ===== design/text_mode_terminal_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core
// Character-stream writer into a text screen store with cursor and scroll.
// ----------------------------------------------------------------------------
// One char_code item in, one result item out. Backspace, tab, newline and
// carriage return move the cursor; every other code is written as a cell
// {text_attribute, code} at the cursor, which then advances. The result
// carries the new linear cursor position and the cell write, if any. The
// screen lives in a single 2000 x 16 synchronous RAM (one write and one
// read port, registered read data). After an item that does not scroll the
// next one can follow directly, provided the result register is free or
// being emptied. An item that leaves the last row starts a scroll that
// walks the RAM: read-one-row-down/write-back for every cell above the
// bottom row, then blanking of the bottom row, with char_stall high
// throughout. After reset a clearing pass writes a blank cell with
// attribute 0x0F to every entry before the first item is taken. The
// result of the scrolling item is presented at once and can be taken
// during the scroll.
// Configuration writes (text_attribute) are always ready; they take effect
// on the next item. Blank cells made by a scroll use the attribute that was
// current when the scrolling item was accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_mode_terminal_writer_core_defines.svh"

module text_mode_terminal_writer_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// character item channel
	input  wire logic                     char_valid,
	output logic                          char_stall,
	input  wire tmtw_pkg::code_t          char_code,
	// result item channel
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output tmtw_pkg::out_idx_t            cursor_position,
	output logic                          cursor_update,
	output logic                          cell_write,
	output tmtw_pkg::out_idx_t            cell_index,
	output tmtw_pkg::cell_t               cell_value,
	output logic                          scrolled,
	// text_attribute register write
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire tmtw_pkg::attr_t          cfg_data
);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	tmtw_pkg::state_t state_q, state_nxt;
	tmtw_pkg::addr_t  sweep_q;
	logic             sweep_end;

	tmtw_pkg::col_t   cursor_col_q;
	tmtw_pkg::row_t   cursor_row_q;
	tmtw_pkg::addr_t  cursor_pos_q;   // row * COLUMNS + col, kept incrementally
	tmtw_pkg::attr_t  attr_q;
	tmtw_pkg::attr_t  blank_attr_q;   // attribute for the scroll's bottom row

	// screen RAM
	tmtw_pkg::cell_t  screen_mem [tmtw_pkg::CELLS];
	tmtw_pkg::cell_t  rd_data_q;
	tmtw_pkg::addr_t  rd_addr;
	logic             rd_en;

	// write stage: every RAM write passes through here, one per cycle
	logic             wr_en_s1;
	tmtw_pkg::addr_t  wr_addr_s1;
	logic             wr_from_rd_s1;
	tmtw_pkg::cell_t  wr_data_s1;
	tmtw_pkg::cell_t  wr_data;

	logic             issue_en;
	tmtw_pkg::addr_t  issue_addr;
	logic             issue_from_rd;
	tmtw_pkg::cell_t  issue_data;

	// result register
	logic             result_valid_q;
	tmtw_pkg::addr_t  res_pos_q;
	logic             res_upd_q;
	logic             res_wr_q;
	tmtw_pkg::addr_t  res_idx_q;
	tmtw_pkg::cell_t  res_val_q;
	logic             res_scr_q;

	// item decode
	logic             accept;
	tmtw_pkg::col_t   nxt_col;
	tmtw_pkg::row_t   nxt_row;
	tmtw_pkg::addr_t  nxt_pos;
	tmtw_pkg::addr_t  line_base;
	tmtw_pkg::colx_t  tab_col;
	logic             item_upd;
	logic             item_wr;
	tmtw_pkg::addr_t  item_idx;
	tmtw_pkg::cell_t  item_val;
	logic             item_wrap;
	logic             item_scroll;

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign cfg_ready    = 1'b1;
	assign char_stall   = !((state_q == tmtw_pkg::ST_IDLE) && (!result_valid_q || !result_stall));
	assign accept       = char_valid && !char_stall;
	assign result_valid = result_valid_q;

	// ------------------------------------------------------------------
	// cursor step for one item
	// ------------------------------------------------------------------
	always_comb begin
		nxt_col   = cursor_col_q;
		nxt_row   = cursor_row_q;
		nxt_pos   = cursor_pos_q;
		line_base = cursor_pos_q - tmtw_pkg::addr_t'(cursor_col_q);
		tab_col   = (tmtw_pkg::colx_t'(cursor_col_q) + tmtw_pkg::colx_t'(tmtw_pkg::TAB_STOP))
		            & ~tmtw_pkg::colx_t'(tmtw_pkg::TAB_STOP - 1);
		item_upd  = 1'b1;
		item_wr   = 1'b0;
		item_idx  = '0;
		item_val  = '0;
		item_wrap = 1'b0;
		item_scroll = 1'b0;

		unique case (char_code)
			tmtw_pkg::CODE_BACKSPACE: begin
				if (cursor_col_q != '0) begin
					nxt_col = cursor_col_q - 1'b1;
					nxt_pos = cursor_pos_q - 1'b1;
				end else if (cursor_row_q != '0) begin
					// wrap to the last column of the row above
					nxt_col = tmtw_pkg::col_t'(tmtw_pkg::COLUMNS - 1);
					nxt_row = cursor_row_q - 1'b1;
					nxt_pos = cursor_pos_q - 1'b1;
				end else begin
					item_upd = 1'b0;
				end
				if (item_upd) begin
					item_wr  = 1'b1;
					item_idx = cursor_pos_q - 1'b1;
					item_val = {attr_q, tmtw_pkg::CODE_SPACE};
				end
			end
			tmtw_pkg::CODE_NEWLINE: begin
				nxt_col   = '0;
				item_wrap = 1'b1;
			end
			tmtw_pkg::CODE_RETURN: begin
				nxt_col = '0;
				nxt_pos = line_base;
			end
			tmtw_pkg::CODE_TAB: begin
				if (tab_col >= tmtw_pkg::colx_t'(tmtw_pkg::COLUMNS)) begin
					nxt_col   = '0;
					item_wrap = 1'b1;
				end else begin
					nxt_col = tab_col[tmtw_pkg::COL_W-1:0];
					nxt_pos = line_base + tmtw_pkg::addr_t'(tab_col);
				end
			end
			default: begin
				item_wr  = 1'b1;
				item_idx = cursor_pos_q;
				item_val = {attr_q, char_code};
				if (cursor_col_q == tmtw_pkg::col_t'(tmtw_pkg::COLUMNS - 1)) begin
					nxt_col   = '0;
					item_wrap = 1'b1;
				end else begin
					nxt_col = cursor_col_q + 1'b1;
					nxt_pos = cursor_pos_q + 1'b1;
				end
			end
		endcase

		// next row, or scroll when on the last one
		if (item_wrap) begin
			if (cursor_row_q == tmtw_pkg::row_t'(tmtw_pkg::ROWS - 1)) begin
				item_scroll = 1'b1;
				nxt_pos     = line_base;
			end else begin
				nxt_row = cursor_row_q + 1'b1;
				nxt_pos = line_base + tmtw_pkg::addr_t'(tmtw_pkg::COLUMNS);
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencer: clear pass, idle, scroll copy, bottom-row blank
	// ------------------------------------------------------------------
	assign sweep_end = (sweep_q == tmtw_pkg::addr_t'(tmtw_pkg::CELLS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tmtw_pkg::ST_CLEAR: if (sweep_end) state_nxt = tmtw_pkg::ST_IDLE;
			tmtw_pkg::ST_IDLE:  if (accept && item_scroll) state_nxt = tmtw_pkg::ST_COPY;
			tmtw_pkg::ST_COPY: begin
				if (sweep_q == tmtw_pkg::addr_t'(tmtw_pkg::CELLS - tmtw_pkg::COLUMNS - 1))
					state_nxt = tmtw_pkg::ST_BLANK;
			end
			tmtw_pkg::ST_BLANK: if (sweep_end) state_nxt = tmtw_pkg::ST_IDLE;
			default:            state_nxt = tmtw_pkg::ST_IDLE;
		endcase
	end

	// RAM access issued by the sequencer
	always_comb begin
		issue_en      = 1'b0;
		issue_addr    = sweep_q;
		issue_from_rd = 1'b0;
		issue_data    = {tmtw_pkg::RESET_ATTR, tmtw_pkg::CODE_SPACE};
		rd_en         = 1'b0;
		rd_addr       = sweep_q + tmtw_pkg::addr_t'(tmtw_pkg::COLUMNS);
		unique case (state_q)
			tmtw_pkg::ST_CLEAR: begin
				issue_en = 1'b1;
			end
			tmtw_pkg::ST_IDLE: begin
				issue_en   = accept && item_wr;
				issue_addr = item_idx;
				issue_data = item_val;
			end
			tmtw_pkg::ST_COPY: begin
				// read one row down now, write it back next cycle
				rd_en         = 1'b1;
				issue_en      = 1'b1;
				issue_from_rd = 1'b1;
			end
			tmtw_pkg::ST_BLANK: begin
				issue_en   = 1'b1;
				issue_data = {blank_attr_q, tmtw_pkg::CODE_SPACE};
			end
			default: begin
				issue_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmtw_pkg::ST_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q != tmtw_pkg::ST_IDLE) begin
				if (state_q != tmtw_pkg::ST_COPY && sweep_end)
					sweep_q <= '0;
				else
					sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// cursor and attribute
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			cursor_pos_q <= '0;
			attr_q       <= tmtw_pkg::RESET_ATTR;
		end else begin
			if (accept) begin
				cursor_col_q <= nxt_col;
				cursor_row_q <= nxt_row;
				cursor_pos_q <= nxt_pos;
			end
			if (cfg_valid && cfg_ready)
				attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			blank_attr_q <= attr_q;
	end

	// ------------------------------------------------------------------
	// write stage and screen RAM
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_en_s1 <= 1'b0;
		else
			wr_en_s1 <= issue_en;
	end

	always_ff @(posedge clk) begin
		wr_addr_s1    <= issue_addr;
		wr_from_rd_s1 <= issue_from_rd;
		wr_data_s1    <= issue_data;
	end

	assign wr_data = wr_from_rd_s1 ? rd_data_q : wr_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en_s1)
			screen_mem[wr_addr_s1] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= screen_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (accept)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_pos_q <= nxt_pos;
			res_upd_q <= item_upd;
			res_wr_q  <= item_wr;
			res_idx_q <= item_idx;
			res_val_q <= item_val;
			res_scr_q <= item_scroll;
		end
	end

	assign cursor_position = tmtw_pkg::out_idx_t'(res_pos_q);
	assign cursor_update   = res_upd_q;
	assign cell_write      = res_wr_q;
	assign cell_index      = tmtw_pkg::out_idx_t'(res_idx_q);
	assign cell_value      = res_val_q;
	assign scrolled        = res_scr_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`TMTW_ASSERT_ALWAYS(a_cursor_range, (int'(cursor_col_q) < tmtw_pkg::COLUMNS) && (int'(cursor_row_q) < tmtw_pkg::ROWS), "cursor outside the screen")
	`TMTW_ASSERT_ALWAYS(a_pos_match, int'(cursor_pos_q) == int'(cursor_row_q) * tmtw_pkg::COLUMNS + int'(cursor_col_q), "linear cursor out of step with row and column")
	`TMTW_ASSERT_NEXT(a_scroll_walk, accept && item_scroll, state_q == tmtw_pkg::ST_COPY, "scrolling item did not start the copy")
	`TMTW_ASSERT_ALWAYS(a_copy_addr, !(wr_en_s1 && wr_from_rd_s1) || (int'(wr_addr_s1) < tmtw_pkg::CELLS - tmtw_pkg::COLUMNS), "scroll copy wrote into the bottom row")

endmodule

`default_nettype wire

// ===== tb/sv/text_mode_terminal_writer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core_tb
// Self-checking bench for the text-mode terminal writer. Character items go
// in through the valid/stall channel and each one is run through a cursor
// predictor. Every result item is matched field by field against the oldest
// prediction. Four pacing phases, each with its own text attribute, follow a
// short opening run over the control codes and the row wrap cases.
// ----------------------------------------------------------------------------

// one result item as the block reports it
typedef struct packed {
	tmtw_pkg::out_idx_t position;
	logic               update;
	logic               written;
	tmtw_pkg::out_idx_t index;
	tmtw_pkg::cell_t    value;
	logic               scrolled;
} cursor_report_t;

class tmtw_scoreboard;
	cursor_report_t  pending_reports[$];
	int unsigned     column;
	int unsigned     row;
	tmtw_pkg::attr_t attribute;
	int unsigned     mismatches;
	int unsigned     checked;
	int unsigned     scrolls;
	int unsigned     origin_backspaces;

	function new();
		column            = 0;
		row               = 0;
		attribute         = tmtw_pkg::RESET_ATTR;
		mismatches        = 0;
		checked           = 0;
		scrolls           = 0;
		origin_backspaces = 0;
	endfunction

	function void set_attribute(tmtw_pkg::attr_t attr);
		attribute = attr;
	endfunction

	function int pending();
		return pending_reports.size();
	endfunction

	// step down one row; below the last row the screen scrolls instead
	function logic next_row();
		row++;
		if (row >= tmtw_pkg::ROWS) begin
			row = tmtw_pkg::ROWS - 1;
			scrolls++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// predict the result of one accepted character item
	function void note_char(tmtw_pkg::code_t code);
		cursor_report_t want;
		want        = '0;
		want.update = 1'b1;
		case (code)
			tmtw_pkg::CODE_BACKSPACE: begin
				if (column > 0) begin
					column--;
				end else if (row > 0) begin
					row--;
					column = tmtw_pkg::COLUMNS - 1;
				end else begin
					want.update = 1'b0;
					origin_backspaces++;
				end
				if (want.update) begin
					want.written = 1'b1;
					want.index   = tmtw_pkg::out_idx_t'(row * tmtw_pkg::COLUMNS + column);
					want.value   = {attribute, tmtw_pkg::CODE_SPACE};
				end
			end
			tmtw_pkg::CODE_NEWLINE: begin
				column        = 0;
				want.scrolled = next_row();
			end
			tmtw_pkg::CODE_RETURN: begin
				column = 0;
			end
			tmtw_pkg::CODE_TAB: begin
				column = (column + tmtw_pkg::TAB_STOP) / tmtw_pkg::TAB_STOP
				         * tmtw_pkg::TAB_STOP;
				if (column >= tmtw_pkg::COLUMNS) begin
					column        = 0;
					want.scrolled = next_row();
				end
			end
			default: begin
				want.written = 1'b1;
				want.index   = tmtw_pkg::out_idx_t'(row * tmtw_pkg::COLUMNS + column);
				want.value   = {attribute, code};
				column++;
				if (column >= tmtw_pkg::COLUMNS) begin
					column        = 0;
					want.scrolled = next_row();
				end
			end
		endcase
		want.position = tmtw_pkg::out_idx_t'(row * tmtw_pkg::COLUMNS + column);
		pending_reports.push_back(want);
	endfunction

	function void check_result(cursor_report_t got);
		cursor_report_t want;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing pending: pos %0d upd %0b wr %0b idx %0d val %h scr %0b",
					$time, got.position, got.update, got.written, got.index, got.value,
					got.scrolled);
			return;
		end
		want = pending_reports.pop_front();
		checked++;
		if (got.position !== want.position || got.update !== want.update ||
				got.written !== want.written || got.index !== want.index ||
				got.value !== want.value || got.scrolled !== want.scrolled) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result %0d differs", $time, checked);
				$display("  expected pos %0d upd %0b wr %0b idx %0d val %h scr %0b",
					want.position, want.update, want.written, want.index, want.value,
					want.scrolled);
				$display("  actual   pos %0d upd %0b wr %0b idx %0d val %h scr %0b",
					got.position, got.update, got.written, got.index, got.value,
					got.scrolled);
			end
		end
	endfunction
endclass

module text_mode_terminal_writer_core_tb;

	logic               clk;
	logic               arst_n;
	logic               char_valid;
	logic               char_stall;
	tmtw_pkg::code_t    char_code;
	logic               result_valid;
	logic               result_stall;
	tmtw_pkg::out_idx_t cursor_position;
	logic               cursor_update;
	logic               cell_write;
	tmtw_pkg::out_idx_t cell_index;
	tmtw_pkg::cell_t    cell_value;
	logic               scrolled;
	logic               cfg_valid;
	logic               cfg_ready;
	tmtw_pkg::attr_t    cfg_data;

	tmtw_scoreboard sb;
	cursor_report_t seen_report;

	// pacing knobs, in percent per cycle
	int unsigned char_gap_pct;
	int unsigned result_stall_pct;

	int unsigned chars_sent;
	int unsigned attribute_writes;

	// opening run: origin backspace, field extremes, codes next to the
	// control codes, row wrap by character, tab and backspace
	tmtw_pkg::code_t opening_codes [0:22] = '{
		tmtw_pkg::CODE_BACKSPACE, 8'h41, 8'h00, 8'hFF, 8'h07, 8'h0B, 8'h0C, 8'h0E,
		tmtw_pkg::CODE_TAB, tmtw_pkg::CODE_RETURN, tmtw_pkg::CODE_BACKSPACE,
		tmtw_pkg::CODE_NEWLINE, tmtw_pkg::CODE_BACKSPACE,
		8'h7A, tmtw_pkg::CODE_BACKSPACE, tmtw_pkg::CODE_TAB, tmtw_pkg::CODE_TAB,
		8'h80, 8'h7F,
		tmtw_pkg::CODE_BACKSPACE, tmtw_pkg::CODE_NEWLINE, tmtw_pkg::CODE_RETURN,
		tmtw_pkg::CODE_SPACE
	};

	text_mode_terminal_writer_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.cursor_position (cursor_position),
		.cursor_update   (cursor_update),
		.cell_write      (cell_write),
		.cell_index      (cell_index),
		.cell_value      (cell_value),
		.scrolled        (scrolled),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop: even if every item scrolled, a legal run stays well below this
	initial begin
		#240_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: stall decided at the falling edge, item taken at the rising edge
	always @(negedge clk) begin
		result_stall <= (result_stall_pct != 0) && ($urandom_range(0, 99) < result_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			seen_report.position = cursor_position;
			seen_report.update   = cursor_update;
			seen_report.written  = cell_write;
			seen_report.index    = cell_index;
			seen_report.value    = cell_value;
			seen_report.scrolled = scrolled;
			sb.check_result(seen_report);
		end
	end

	// Present one character item and hold it until taken. Entered and left
	// at a falling edge; valid only drops when a gap is inserted, so a
	// back-to-back item keeps valid high across the boundary.
	task automatic send_char(input tmtw_pkg::code_t code);
		if (char_gap_pct != 0 && $urandom_range(0, 99) < char_gap_pct) begin
			char_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < char_gap_pct);
		end
		char_valid <= 1'b1;
		char_code  <= code;
		do @(posedge clk); while (char_stall);
		sb.note_char(code);
		chars_sent++;
		@(negedge clk);
	endtask

	// Sender holds off until every result is back and no scroll is running.
	task automatic wait_idle();
		char_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || char_stall);
		@(negedge clk);
	endtask

	task automatic write_attribute(input tmtw_pkg::attr_t attr);
		cfg_valid <= 1'b1;
		cfg_data  <= attr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_attribute(attr);
		attribute_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random text: mostly printable bytes, with control codes mixed in and an
	// occasional run of backspaces long enough to climb back over row starts.
	task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
			input int unsigned count);
		int unsigned sent;
		int unsigned pick;
		int unsigned burst;
		char_gap_pct     = gap_pct;
		result_stall_pct = stall_pct;
		sent             = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 999);
			if (pick < 5) begin
				burst = $urandom_range(2, 90);
				repeat (burst) send_char(tmtw_pkg::CODE_BACKSPACE);
				sent += burst;
			end else begin
				if (pick < 65)
					send_char(tmtw_pkg::CODE_BACKSPACE);
				else if (pick < 95)
					send_char(tmtw_pkg::CODE_NEWLINE);
				else if (pick < 125)
					send_char(tmtw_pkg::CODE_RETURN);
				else if (pick < 175)
					send_char(tmtw_pkg::CODE_TAB);
				else
					send_char(tmtw_pkg::code_t'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	initial begin
		sb               = new();
		arst_n           = 1'b0;
		char_valid       = 1'b0;
		char_code        = '0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		result_stall     = 1'b0;
		char_gap_pct     = 0;
		result_stall_pct = 0;
		chars_sent       = 0;
		attribute_writes = 0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// opening run at full rate; the first item waits out the clearing pass
		foreach (opening_codes[i]) begin
			if (i == 13) begin
				// new attribute from here on; earlier cells keep 0x0F
				wait_idle();
				write_attribute(8'hA5);
			end
			send_char(opening_codes[i]);
		end

		// each phase starts from an empty pipeline with a fresh attribute
		wait_idle();
		write_attribute(8'h00);
		run_phase(0, 0, 450);

		wait_idle();
		write_attribute(8'hFF);
		run_phase(63, 0, 450);

		wait_idle();
		write_attribute(tmtw_pkg::attr_t'($urandom_range(0, 255)));
		run_phase(0, 63, 450);

		wait_idle();
		write_attribute(tmtw_pkg::attr_t'($urandom_range(0, 255)));
		run_phase(20, 20, 450);

		wait_idle();
		// a quiet stretch so a stray result would still be caught
		repeat (32) @(posedge clk);

		$display("Sent %0d characters, checked %0d results, %0d attribute writes.",
			chars_sent, sb.checked, attribute_writes);
		$display("Saw %0d scrolls and %0d backspaces at the origin; %0d mismatches.",
			sb.scrolls, sb.origin_backspaces, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
